// ----- design/tpsp_pkg.sv -----
// Shared types, codes and constants of the touch panel SPI poller.
`timescale 1ns / 1ps
`default_nettype none

package tpsp_pkg;

  // Input item codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SPI  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [7:0] INTERVAL_RESET = 8'd64;

  // Touch controller command words
  localparam logic [7:0] CMD_X    = 8'hD0;
  localparam logic [7:0] CMD_Y    = 8'h90;
  localparam logic [7:0] CMD_Z1   = 8'hB0;
  localparam logic [7:0] CMD_Z2   = 8'hC0;
  localparam logic [7:0] CMD_NONE = 8'h00;

  // Burst sequencing: index counts down from BURST_START to 0
  localparam logic [2:0] BURST_START = 3'd4;
  localparam logic [2:0] IDX_X       = 3'd0;
  localparam logic [2:0] IDX_Y       = 3'd1;
  localparam int unsigned POS_SHIFT  = 3;
  localparam int unsigned POS_W      = 12;

  // Result queue depth (must hold the two results of one item)
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_SELECT   = 3'd0,
    EV_NEXT     = 3'd1,
    EV_DESELECT = 3'd2,
    EV_REPORT   = 3'd3,
    EV_RELEASE  = 3'd4
  } event_e;

  typedef struct packed {
    logic        mode;
    logic        pen_up;
    logic [15:0] rx_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       tx_word;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic             last;
  } res_item_t;

  // Up to two results handed from the core to the result queue
  typedef struct packed {
    logic [1:0]           num;
    res_item_t [1:0]      item;
  } push_t;

  // Command sent ahead of the word stored under the given index
  function automatic logic [7:0] burst_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      3'd1:    cmd = CMD_X;
      3'd2:    cmd = CMD_Y;
      3'd3:    cmd = CMD_Z1;
      3'd4:    cmd = CMD_Z2;
      default: cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

// ----- design/tpsp_if.sv -----
// Handshake channels of the touch panel SPI poller: input items and results.
`timescale 1ns / 1ps
`default_nettype none

interface tpsp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        pen_up;
  logic [15:0] rx_word;

  modport source (output valid, output mode, output pen_up, output rx_word, input ready);
  modport sink (input valid, input mode, input pen_up, input rx_word, output ready);
endinterface

interface tpsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  tx_word;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic        last;

  modport source (output valid, output event_res, output tx_word, output x_pos,
                  output y_pos, output last, input ready);
  modport sink (input valid, input event_res, input tx_word, input x_pos,
                input y_pos, input last, output ready);
endinterface

`default_nettype wire

// ----- design/tpsp_core.sv -----
// Input register, configuration, poll/burst state and result decode.
`timescale 1ns / 1ps
`default_nettype none

module tpsp_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tpsp_in_if.sink                              in_i,
  input  logic                                 cfg_we_i,
  input  logic [tpsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tpsp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 room_i,
  output tpsp_pkg::push_t                      push_o
);

  logic                        in_valid_q;
  tpsp_pkg::in_item_t          in_item_q;
  logic                        fire;
  logic                        poll;

  logic                        enable_q;
  logic [7:0]                  interval_q;
  logic [7:0]                  tick_count_q, tick_count_d;
  logic                        pen_down_q, pen_down_d;
  logic [2:0]                  burst_idx_q, burst_idx_d;
  logic                        burst_active_q, burst_active_d;
  logic [tpsp_pkg::POS_W-1:0]  x_q, x_d;
  logic [tpsp_pkg::POS_W-1:0]  y_q, y_d;
  logic [8:0]                  cnt;

  // Item moves on once the queue can take two results
  assign fire       = in_valid_q && room_i;
  assign in_i.ready = !in_valid_q || fire;
  assign cnt        = {1'b0, tick_count_q} + 9'd1;
  assign poll       = cnt >= {1'b0, interval_q};

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= '{mode: in_i.mode, pen_up: in_i.pen_up, rx_word: in_i.rx_word};
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      interval_q <= tpsp_pkg::INTERVAL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tpsp_pkg::CFG_ENABLE) begin
        enable_q <= cfg_wdata_i[0];
      end
      if (cfg_idx_i == tpsp_pkg::CFG_INTERVAL) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  // Poll and burst decode
  always_comb begin
    tick_count_d   = tick_count_q;
    pen_down_d     = pen_down_q;
    burst_idx_d    = burst_idx_q;
    burst_active_d = burst_active_q;
    x_d            = x_q;
    y_d            = y_q;
    push_o         = '0;

    if (fire) begin
      if (in_item_q.mode == tpsp_pkg::MODE_TICK) begin
        if (enable_q) begin
          if (!poll) begin
            tick_count_d = cnt[7:0];
          end else begin
            tick_count_d = '0;
            // Report from the last burst comes first
            if (pen_down_q) begin
              push_o.item[push_o.num[0]].event_res = tpsp_pkg::EV_REPORT;
              push_o.item[push_o.num[0]].x_pos     = x_q;
              push_o.item[push_o.num[0]].y_pos     = y_q;
              push_o.num = push_o.num + 2'd1;
            end
            if (in_item_q.pen_up) begin
              if (pen_down_q) begin
                pen_down_d = 1'b0;
                push_o.item[push_o.num[0]].event_res = tpsp_pkg::EV_RELEASE;
                push_o.num = push_o.num + 2'd1;
              end
            end else begin
              pen_down_d     = 1'b1;
              burst_idx_d    = tpsp_pkg::BURST_START;
              burst_active_d = 1'b1;
              push_o.item[push_o.num[0]].event_res = tpsp_pkg::EV_SELECT;
              push_o.item[push_o.num[0]].tx_word   =
                tpsp_pkg::burst_cmd(tpsp_pkg::BURST_START);
              push_o.num = push_o.num + 2'd1;
            end
          end
        end
      end else if (burst_active_q) begin
        // Only the X and Y words are ever reported; keep bits 14..3
        if (burst_idx_q == tpsp_pkg::IDX_X) begin
          x_d = in_item_q.rx_word[tpsp_pkg::POS_SHIFT +: tpsp_pkg::POS_W];
        end
        if (burst_idx_q == tpsp_pkg::IDX_Y) begin
          y_d = in_item_q.rx_word[tpsp_pkg::POS_SHIFT +: tpsp_pkg::POS_W];
        end
        if (burst_idx_q != 3'd0) begin
          burst_idx_d = burst_idx_q - 3'd1;
          push_o.item[0].event_res = tpsp_pkg::EV_NEXT;
          push_o.item[0].tx_word   = tpsp_pkg::burst_cmd(burst_idx_q - 3'd1);
        end else begin
          burst_active_d = 1'b0;
          push_o.item[0].event_res = tpsp_pkg::EV_DESELECT;
        end
        push_o.num = 2'd1;
      end

      // Mark the final result of this item
      if (push_o.num == 2'd1) begin
        push_o.item[0].last = 1'b1;
      end else if (push_o.num == 2'd2) begin
        push_o.item[1].last = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q   <= '0;
      pen_down_q     <= 1'b0;
      burst_idx_q    <= '0;
      burst_active_q <= 1'b0;
      x_q            <= '0;
      y_q            <= '0;
    end else begin
      tick_count_q   <= tick_count_d;
      pen_down_q     <= pen_down_d;
      burst_idx_q    <= burst_idx_d;
      burst_active_q <= burst_active_d;
      x_q            <= x_d;
      y_q            <= y_d;
    end
  end

  // Burst index never leaves the command range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_idx_q <= tpsp_pkg::BURST_START)
    else $error("burst index out of range");

  // A poll with the pen down starts a fresh burst
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_item_q.mode == tpsp_pkg::MODE_TICK && enable_q && poll && !in_item_q.pen_up
    |=> burst_active_q && burst_idx_q == tpsp_pkg::BURST_START)
    else $error("poll did not start a burst");

  // Words outside a burst give no result
  a_stray_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_item_q.mode == tpsp_pkg::MODE_SPI && !burst_active_q |-> push_o.num == 2'd0)
    else $error("stray word produced a result");

endmodule

`default_nettype wire

// ----- design/tpsp_res_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while the output is ready.
`timescale 1ns / 1ps
`default_nettype none

module tpsp_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpsp_pkg::push_t  push_i,
  output logic             room_o,
  tpsp_out_if.source       out_o
);

  tpsp_pkg::res_item_t                 mem_q [tpsp_pkg::RQ_DEPTH];
  logic [tpsp_pkg::RQ_PTR_W-1:0]       wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [tpsp_pkg::RQ_CNT_W-1:0]       count_q;
  logic                                pop;
  tpsp_pkg::res_item_t                 head;

  assign wr_ptr_nx = wr_ptr_q + tpsp_pkg::RQ_PTR_W'(1);
  assign room_o    = count_q <= tpsp_pkg::RQ_CNT_W'(tpsp_pkg::RQ_DEPTH - 2);
  assign pop       = out_o.valid && out_o.ready;

  // Head of queue drives the output channel
  assign head            = mem_q[rd_ptr_q];
  assign out_o.valid     = count_q != '0;
  assign out_o.event_res = head.event_res;
  assign out_o.tx_word   = head.tx_word;
  assign out_o.x_pos     = head.x_pos;
  assign out_o.y_pos     = head.y_pos;
  assign out_o.last      = head.last;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.item[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.item[1];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + tpsp_pkg::RQ_PTR_W'(push_i.num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + tpsp_pkg::RQ_PTR_W'(1);
      end
      count_q <= count_q + tpsp_pkg::RQ_CNT_W'(push_i.num) - tpsp_pkg::RQ_CNT_W'(pop);
    end
  end

  // Results only arrive when two slots are free
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("result queue overflow");

  // Fill count follows pushes and pops
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + tpsp_pkg::RQ_CNT_W'($past(push_i.num))
                        - tpsp_pkg::RQ_CNT_W'($past(pop)))
    else $error("result queue count mismatch");

endmodule

`default_nettype wire

// ----- design/touch_panel_spi_poller_unit.sv -----
// Top level of the touch panel SPI poller.
`timescale 1ns / 1ps
`default_nettype none

// Polls a resistive touch controller over a 16-bit SPI link. Input items are
// millisecond ticks (mode 0) or received SPI words (mode 1); each item gives
// zero, one or two result items (select/send, send next, deselect, position
// report, pen released), the final one flagged by last. A new item is taken
// every cycle while the four-entry result queue has two free slots; results
// leave the queue one per cycle while the output is ready, so items that yield
// two results hold back the input at sustained rate. An accepted item passes
// the input register and then the result queue storage on its way out. Register
// writes (enable, poll interval) are to be made while the block is idle.
module touch_panel_spi_poller_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tpsp_in_if.sink                              in_i,
  tpsp_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [tpsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tpsp_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  tpsp_pkg::push_t push;
  logic            room;

  tpsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .room_i      (room),
    .push_o      (push)
  );

  tpsp_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
